[hdl/led_strip_pulse_encoder_top_defines.svh]
// Assertion macros used by the pulse encoder top level.
`ifndef LED_STRIP_PULSE_ENCODER_TOP_DEFINES_SVH
`define LED_STRIP_PULSE_ENCODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define LPE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("lpe assertion failed");
`define LPE_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("lpe forbidden condition seen");
`else
`define LPE_ASSERT(lbl, clk, rstn, prop)
`define LPE_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

[hdl/lpe_pkg.sv]
// Types and constants of the LED strip pulse encoder.
package lpe_pkg;

  localparam int CFG_W          = 10;
  localparam int BYTE_W         = 8;
  localparam int BITS_PER_PIXEL = 24;
  localparam int CNT_W          = 5;
  localparam int CFG_IDX_W      = 3;

  localparam logic [CFG_W-1:0] ONE_HIGH_RST  = 10'd12;
  localparam logic [CFG_W-1:0] ONE_LOW_RST   = 10'd7;
  localparam logic [CFG_W-1:0] ZERO_HIGH_RST = 10'd6;
  localparam logic [CFG_W-1:0] ZERO_LOW_RST  = 10'd13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ONE_HIGH  = 3'd0,
    REG_ONE_LOW   = 3'd1,
    REG_ZERO_HIGH = 3'd2,
    REG_ZERO_LOW  = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] blue;
    logic              last_pixel;
  } pixel_t;

  typedef struct packed {
    logic             bit_value;
    logic [CFG_W-1:0] high_time;
    logic [CFG_W-1:0] low_time;
    logic             pixel_done;
    logic             frame_done;
  } pulse_t;

  typedef struct packed {
    logic [CFG_W-1:0] one_high;
    logic [CFG_W-1:0] one_low;
    logic [CFG_W-1:0] zero_high;
    logic [CFG_W-1:0] zero_low;
  } timing_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] count;
  } ser_status_t;

endpackage

[hdl/lpe_scaler.sv]
// Brightness scaling: divides each color byte by a constant via reciprocal multiply.
module lpe_scaler #(
  parameter int BRIGHTNESS_DIVISOR = 6
) (
  input  lpe_pkg::pixel_t pix_in,
  output lpe_pkg::pixel_t pix_out
);

  localparam int DIV     = (BRIGHTNESS_DIVISOR == 0) ? 1 : BRIGHTNESS_DIVISOR;
  localparam int SHIFT   = 2 * lpe_pkg::BYTE_W;
  localparam int RECIP   = ((1 << SHIFT) + DIV - 1) / DIV;
  localparam int RECIP_W = SHIFT + 1;
  localparam int PROD_W  = RECIP_W + lpe_pkg::BYTE_W;

  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  function automatic logic [lpe_pkg::BYTE_W-1:0] scale(input logic [lpe_pkg::BYTE_W-1:0] v);
    logic [PROD_W-1:0] prod;
    prod  = PROD_W'(v) * PROD_W'(RECIP_C);
    scale = prod[SHIFT +: lpe_pkg::BYTE_W];
  endfunction

  always_comb begin
    pix_out.green      = scale(pix_in.green);
    pix_out.red        = scale(pix_in.red);
    pix_out.blue       = scale(pix_in.blue);
    pix_out.last_pixel = pix_in.last_pixel;
  end

endmodule

[hdl/lpe_serializer.sv]
// Bit serializer: shifts out 24 pulse descriptors per pixel into an output register.
module lpe_serializer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lpe_pkg::pixel_t      pix,
  input  lpe_pkg::timing_t     timing,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lpe_pkg::pulse_t      out_data,
  output lpe_pkg::ser_status_t status
);

  logic [lpe_pkg::BITS_PER_PIXEL-1:0] bits_r, bits_nxt;
  logic [lpe_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                               busy_r, busy_nxt;
  logic                               last_r, last_nxt;
  logic                               out_valid_r, out_valid_nxt;
  lpe_pkg::pulse_t                    out_data_r, out_data_nxt;

  logic adv, at_end, load, cur_bit;

  assign adv      = busy_r && (!out_valid_r || out_ready);
  assign at_end   = (cnt_r == lpe_pkg::CNT_W'(lpe_pkg::BITS_PER_PIXEL - 1));
  assign in_ready = !busy_r || (adv && at_end);
  assign load     = in_valid && in_ready;
  assign cur_bit  = bits_r[lpe_pkg::BITS_PER_PIXEL-1];

  always_comb begin
    bits_nxt      = bits_r;
    cnt_nxt       = cnt_r;
    busy_nxt      = busy_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      bits_nxt = {pix.green, pix.red, pix.blue};
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      last_nxt = pix.last_pixel;
    end else if (adv) begin
      bits_nxt = bits_r << 1;
      cnt_nxt  = cnt_r + 1'b1;
      if (at_end) begin
        busy_nxt = 1'b0;
        cnt_nxt  = '0;
      end
    end
    if (adv) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.bit_value  = cur_bit;
      out_data_nxt.high_time  = cur_bit ? timing.one_high : timing.zero_high;
      out_data_nxt.low_time   = cur_bit ? timing.one_low : timing.zero_low;
      out_data_nxt.pixel_done = at_end;
      out_data_nxt.frame_done = at_end && last_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bits_r     <= bits_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign status.busy  = busy_r;
  assign status.count = cnt_r;

endmodule

[hdl/led_strip_pulse_encoder_top.sv]
// LED strip pulse encoder: timing registers, brightness scaler and serializer.
// The first pulse descriptor is registered after the accepted pixel is loaded into the shift register.
// The bit shifter gives one descriptor per cycle while out_ready does not stall it;
// the next pixel is taken in the cycle its predecessor's last bit is sent.
// Reset (synchronous, rst_n low): pipeline empties, timing registers return to
// 12/7/6/13.
`include "led_strip_pulse_encoder_top_defines.svh"

module led_strip_pulse_encoder_top #(
  parameter int BRIGHTNESS_DIVISOR = 6
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lpe_pkg::pixel_t                     in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lpe_pkg::pulse_t                     out_data,
  input  logic                                cfg_wr_en,
  input  logic [lpe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lpe_pkg::CFG_W-1:0]           cfg_wdata
);

  lpe_pkg::timing_t     timing_r, timing_nxt;
  lpe_pkg::pixel_t      pix_scaled;
  lpe_pkg::ser_status_t ser_status;

  always_comb begin
    timing_nxt = timing_r;
    if (cfg_wr_en) begin
      unique case (lpe_pkg::cfg_reg_e'(cfg_index))
        lpe_pkg::REG_ONE_HIGH:  timing_nxt.one_high  = cfg_wdata;
        lpe_pkg::REG_ONE_LOW:   timing_nxt.one_low   = cfg_wdata;
        lpe_pkg::REG_ZERO_HIGH: timing_nxt.zero_high = cfg_wdata;
        lpe_pkg::REG_ZERO_LOW:  timing_nxt.zero_low  = cfg_wdata;
        default:                timing_nxt = timing_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.one_high  <= lpe_pkg::ONE_HIGH_RST;
      timing_r.one_low   <= lpe_pkg::ONE_LOW_RST;
      timing_r.zero_high <= lpe_pkg::ZERO_HIGH_RST;
      timing_r.zero_low  <= lpe_pkg::ZERO_LOW_RST;
    end else begin
      timing_r <= timing_nxt;
    end
  end

  lpe_scaler #(
    .BRIGHTNESS_DIVISOR(BRIGHTNESS_DIVISOR)
  ) u_scaler (
    .pix_in (in_data),
    .pix_out(pix_scaled)
  );

  lpe_serializer u_serializer (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .pix      (pix_scaled),
    .timing   (timing_r),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .status   (ser_status)
  );

  `LPE_ASSERT(a_frame_implies_pixel, clk, rst_n, out_valid |-> (!out_data.frame_done || out_data.pixel_done))
  `LPE_ASSERT(a_accept_sets_busy, clk, rst_n, (in_valid && in_ready) |=> (ser_status.busy && ser_status.count == '0))
  `LPE_ASSERT(a_out_from_busy, clk, rst_n, $rose(out_valid) |-> $past(ser_status.busy))
  `LPE_ASSERT_NEVER(a_idle_count_zero, clk, rst_n, !ser_status.busy && $past(rst_n) && ser_status.count != '0)

endmodule
